// ===== hw/rtl/bba_pkg.sv =====
// Shared types, codes and constants of the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

   // Default sizing of the bitmap
   localparam int DEF_MAX_BLOCKS = 65536;
   localparam int DEF_WORD_BITS  = 32;

   // Register and field widths
   localparam int REG_W   = 17;
   localparam int BLOCK_W = 16;

   // Bit search walks the inverted word one byte at a time
   localparam int CHUNK_BITS = 8;

   localparam logic [REG_W-1:0] COUNT_MAX     = 17'h1FFFF;
   localparam logic [REG_W-1:0] TOTAL_RESET   = 17'd65536;
   localparam logic [REG_W-1:0] RESERVE_RESET = 17'd0;

   // Configuration register indexes
   typedef enum logic [0:0] {
      REG_TOTAL_BLOCKS    = 1'b0,
      REG_RESERVED_BLOCKS = 1'b1
   } reg_index_type;

   // Command codes
   typedef enum logic [2:0] {
      CMD_ALLOC = 3'd0,
      CMD_FREE  = 3'd1,
      CMD_READ  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_INIT  = 3'd4
   } cmd_type;

   // Status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOSPACE = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [BLOCK_W-1:0] block_number;
      logic               bit_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [BLOCK_W-1:0] result_block;
      logic               bit_read;
      logic [REG_W-1:0]   free_count_out;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator.sv =====
// Top level of the bitmap block allocator: sequencer, bitmap memory and result register.
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/ready    bba_pkg::req_type (cmd, block_number, bit_value)
//   rsp_     out        rsp_valid/ready    bba_pkg::rsp_type (status, result_block, ...)
//   csr_     in         csr_wr_en          csr_index, csr_wdata (17 bits)
//
// Allocate scans the bitmap word by word, then searches the first word with a clear bit
// byte by byte; its pace is set by the single read port of the bitmap memory.
// Free, read and write wait for the registered read of the bitmap word ahead of their
// modify step. WORD_BITS must be a power of two (the block does not check it), so the
// block number splits into word index and bit offset by shift and mask.
// Init sweeps the memory one word a cycle.
// After reset a clearing pass over every bitmap word runs with req_ready low;
// configuration writes are taken during it.
// The result register lets a new transaction be accepted while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator #(
   parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
   parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire  bba_pkg::req_type      req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output bba_pkg::rsp_type            rsp_data,
   input  wire                         csr_wr_en,
   input  wire  [0:0]                  csr_index,
   input  wire  [bba_pkg::REG_W-1:0]   csr_wdata
);

   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int QW_RAW    = $clog2(MAP_WORDS);
   localparam int QW        = (QW_RAW > 0) ? QW_RAW : 1;
   localparam int OW        = $clog2(WORD_BITS);
   localparam int SW        = $clog2(WORD_BITS + 1);
   localparam int CW_RAW    = $clog2(MAP_WORDS * WORD_BITS + WORD_BITS + 1);
   localparam int CW        = (CW_RAW > bba_pkg::REG_W) ? CW_RAW : bba_pkg::REG_W;
   localparam int RW        = bba_pkg::REG_W;
   localparam int BW        = bba_pkg::BLOCK_W;
   localparam int CB        = bba_pkg::CHUNK_BITS;

   localparam logic [CW-1:0] MAX_W     = CW'(MAX_BLOCKS);
   localparam logic [CW-1:0] WB_W      = CW'(WORD_BITS);
   localparam logic [QW-1:0] LAST_WORD = QW'(MAP_WORDS - 1);
   localparam logic [RW-1:0] FREE_RESET =
      (CW'(bba_pkg::TOTAL_RESET) > MAX_W) ? RW'(MAX_BLOCKS) : bba_pkg::TOTAL_RESET;
   localparam logic [WORD_BITS-1:0] ONES    = {WORD_BITS{1'b1}};
   localparam logic [WORD_BITS-1:0] BIT_ONE = WORD_BITS'(1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ALLOC_ADDR,
      S_ALLOC_CHK,
      S_FIND,
      S_MOD_WAIT,
      S_MOD_DO,
      S_SWEEP,
      S_RESP
   } state_type;

   state_type              state_ff;
   logic [RW-1:0]          total_ff;
   logic [RW-1:0]          reserved_ff;
   logic [RW-1:0]          free_ff;
   logic [2:0]             cmd_ff;
   logic [BW-1:0]          blk_ff;
   logic                   bv_ff;
   logic [CW-1:0]          lim_ff;
   logic [CW-1:0]          rsv_ff;
   logic                   init_mode_ff;
   logic [QW-1:0]          word_ff;
   logic [CW-1:0]          base_ff;
   logic [CW-1:0]          nb_ff;
   logic [OW-1:0]          off_ff;
   logic [WORD_BITS-1:0]   inv_ff;
   logic [WORD_BITS-1:0]   wd_ff;
   logic [1:0]             pend_status_ff;
   logic [BW-1:0]          pend_block_ff;
   logic                   pend_bit_ff;
   logic                   rsp_valid_ff;
   bba_pkg::rsp_type       rsp_data_ff;

   logic [WORD_BITS-1:0]   mem_ff [MAP_WORDS];
   logic [WORD_BITS-1:0]   rdata_ff;

   logic                   mem_we;
   logic [WORD_BITS-1:0]   mem_wdata;
   logic [CW-1:0]          eff_total;
   logic [CW-1:0]          rsv_clip;
   logic [WORD_BITS-1:0]   rd_inv;
   logic [CB-1:0]          low_chunk;
   logic [2:0]             chunk_pos;
   logic [CW-1:0]          found_n;
   logic [OW-1:0]          found_off;
   logic [OW-1:0]          mod_off;
   logic                   mod_bit;
   logic [CW-1:0]          sweep_diff;
   logic [WORD_BITS-1:0]   sweep_mask;
   logic                   rsp_free;

   // Lowest set bit of a byte
   function automatic logic [2:0] low_set(input logic [CB-1:0] v);
      logic [2:0] pos;
      pos = 3'd0;
      for (int i = CB - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = 3'(i);
         end
      end
      return pos;
   endfunction

   // Clamp the configured sizes to the bitmap
   always_comb begin
      eff_total = (CW'(total_ff) > MAX_W) ? MAX_W : CW'(total_ff);
      rsv_clip  = (CW'(reserved_ff) > eff_total) ? eff_total : CW'(reserved_ff);
   end

   // Search and modify datapath
   always_comb begin
      rd_inv     = ~rdata_ff;
      low_chunk  = inv_ff[CB-1:0];
      chunk_pos  = low_set(low_chunk);
      found_n    = nb_ff + CW'(chunk_pos);
      found_off  = off_ff + OW'(chunk_pos);
      mod_off    = blk_ff[OW-1:0];
      mod_bit    = rdata_ff[mod_off];
      sweep_diff = rsv_ff - base_ff;
      if (rsv_ff >= base_ff + WB_W) begin
         sweep_mask = ONES;
      end else if (rsv_ff > base_ff) begin
         sweep_mask = ~(ONES << sweep_diff[SW-1:0]);
      end else begin
         sweep_mask = '0;
      end
   end

   // Select the bitmap write
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = sweep_mask;
      unique case (state_ff)
         S_SWEEP: begin
            mem_we    = 1'b1;
            mem_wdata = sweep_mask;
         end
         S_FIND: begin
            mem_we    = (low_chunk != '0) && (found_n < lim_ff);
            mem_wdata = wd_ff | (BIT_ONE << found_off);
         end
         S_MOD_DO: begin
            if (cmd_ff == bba_pkg::CMD_FREE) begin
               mem_we    = mod_bit;
               mem_wdata = rdata_ff & ~(BIT_ONE << mod_off);
            end else if (cmd_ff == bba_pkg::CMD_WRITE) begin
               mem_we    = 1'b1;
               mem_wdata = bv_ff ? (rdata_ff | (BIT_ONE << mod_off))
                                 : (rdata_ff & ~(BIT_ONE << mod_off));
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Bitmap memory: one write and one registered read a cycle at the current word
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[word_ff] <= mem_wdata;
      end
      rdata_ff <= mem_ff[word_ff];
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= bba_pkg::TOTAL_RESET;
         reserved_ff <= bba_pkg::RESERVE_RESET;
      end else if (csr_wr_en) begin
         unique case (bba_pkg::reg_index_type'(csr_index))
            bba_pkg::REG_TOTAL_BLOCKS:    total_ff    <= csr_wdata;
            bba_pkg::REG_RESERVED_BLOCKS: reserved_ff <= csr_wdata;
         endcase
      end
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         free_ff      <= FREE_RESET;
         rsv_ff       <= '0;
         init_mode_ff <= 1'b0;
         word_ff      <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the result once taken, unless a new one replaces it
         if (rsp_valid_ff && rsp_ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_data.cmd;
                  blk_ff   <= req_data.block_number;
                  bv_ff    <= req_data.bit_value;
                  lim_ff   <= eff_total;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               pend_bit_ff <= 1'b0;
               unique case (cmd_ff)
                  bba_pkg::CMD_ALLOC: begin
                     word_ff       <= '0;
                     base_ff       <= '0;
                     pend_block_ff <= '0;
                     if (free_ff == '0) begin
                        pend_status_ff <= bba_pkg::ST_NOSPACE;
                        state_ff       <= S_RESP;
                     end else begin
                        pend_status_ff <= bba_pkg::ST_OK;
                        state_ff       <= S_ALLOC_ADDR;
                     end
                  end
                  bba_pkg::CMD_FREE, bba_pkg::CMD_READ, bba_pkg::CMD_WRITE: begin
                     pend_block_ff <= blk_ff;
                     if (CW'(blk_ff) >= lim_ff) begin
                        pend_status_ff <= bba_pkg::ST_RANGE;
                        state_ff       <= S_RESP;
                     end else begin
                        // Split the block number into word index and bit offset
                        pend_status_ff <= bba_pkg::ST_OK;
                        word_ff        <= QW'(CW'(blk_ff) >> OW);
                        state_ff       <= S_MOD_WAIT;
                     end
                  end
                  bba_pkg::CMD_INIT: begin
                     pend_status_ff <= bba_pkg::ST_OK;
                     pend_block_ff  <= blk_ff;
                     word_ff        <= '0;
                     base_ff        <= '0;
                     rsv_ff         <= rsv_clip;
                     init_mode_ff   <= 1'b1;
                     state_ff       <= S_SWEEP;
                  end
                  default: begin
                     pend_status_ff <= bba_pkg::ST_OK;
                     pend_block_ff  <= blk_ff;
                     state_ff       <= S_RESP;
                  end
               endcase
            end
            S_ALLOC_ADDR: begin
               // Stop once the word starts at or past the limit
               if (base_ff >= lim_ff) begin
                  pend_status_ff <= bba_pkg::ST_NOSPACE;
                  pend_block_ff  <= '0;
                  state_ff       <= S_RESP;
               end else begin
                  state_ff <= S_ALLOC_CHK;
               end
            end
            S_ALLOC_CHK: begin
               if (rd_inv != '0) begin
                  inv_ff   <= rd_inv;
                  wd_ff    <= rdata_ff;
                  off_ff   <= '0;
                  nb_ff    <= base_ff;
                  state_ff <= S_FIND;
               end else if (word_ff == LAST_WORD) begin
                  pend_status_ff <= bba_pkg::ST_NOSPACE;
                  pend_block_ff  <= '0;
                  state_ff       <= S_RESP;
               end else begin
                  word_ff  <= word_ff + QW'(1);
                  base_ff  <= base_ff + WB_W;
                  state_ff <= S_ALLOC_ADDR;
               end
            end
            S_FIND: begin
               // Advance one byte of the inverted word until a free bit shows
               if (low_chunk != '0) begin
                  if (found_n < lim_ff) begin
                     free_ff       <= free_ff - RW'(1);
                     pend_block_ff <= found_n[BW-1:0];
                  end else begin
                     pend_status_ff <= bba_pkg::ST_NOSPACE;
                     pend_block_ff  <= '0;
                  end
                  state_ff <= S_RESP;
               end else begin
                  inv_ff <= inv_ff >> CB;
                  off_ff <= off_ff + OW'(CB);
                  nb_ff  <= nb_ff + CW'(CB);
               end
            end
            S_MOD_WAIT: begin
               state_ff <= S_MOD_DO;
            end
            S_MOD_DO: begin
               if (cmd_ff == bba_pkg::CMD_FREE && mod_bit && free_ff != bba_pkg::COUNT_MAX) begin
                  free_ff <= free_ff + RW'(1);
               end
               if (cmd_ff == bba_pkg::CMD_READ) begin
                  pend_bit_ff <= mod_bit;
               end
               state_ff <= S_RESP;
            end
            S_SWEEP: begin
               if (word_ff == LAST_WORD) begin
                  if (init_mode_ff) begin
                     free_ff  <= RW'(lim_ff - rsv_ff);
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_IDLE;
                  end
                  init_mode_ff <= 1'b0;
               end else begin
                  word_ff <= word_ff + QW'(1);
                  base_ff <= base_ff + WB_W;
               end
            end
            S_RESP: begin
               // Hold until the result register is free
               if (rsp_free) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_data_ff.status          <= pend_status_ff;
                  rsp_data_ff.result_block    <= pend_block_ff;
                  rsp_data_ff.bit_read        <= pend_bit_ff;
                  rsp_data_ff.free_count_out  <= free_ff;
                  state_ff                    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // The bitmap is written only by the sweep, the allocate search and the modify step
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_SWEEP || state_ff == S_FIND || state_ff == S_MOD_DO))
      else $error("bitmap written outside a write state");

   // The bit search only runs on a word that has a free bit left
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND) |-> (inv_ff != '0))
      else $error("bit search on a full word");

   // An accepted transaction is decoded in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted transaction not decoded");

   // A result appears only from the result state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("result raised outside the result state");

endmodule

`default_nettype wire

// ===== dv/bba_checker.sv =====
// Scoreboard for the bitmap block allocator: mirrors the map, predicts each reply, compares.
`timescale 1ns / 1ps

module bba_checker
   import bba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [0:0]       csr_index,
   input  logic [REG_W-1:0] csr_wdata,
   output int               mismatches,
   output int               replies_due
);

   localparam int WB        = DEF_WORD_BITS;
   localparam int MAP_WORDS = DEF_MAX_BLOCKS / DEF_WORD_BITS;

   // Mirror of the block's state and registers
   logic [WB-1:0]    usage_words [MAP_WORDS];
   logic [REG_W-1:0] free_tally;
   logic [REG_W-1:0] total_reg;
   logic [REG_W-1:0] reserve_reg;
   rsp_type          due_q [$];
   int               miss_tally;
   rsp_type          want;

   task automatic flag_mismatch(input string what);
      miss_tally++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // Registers above the map size behave as the map size
   function automatic int usable_total();
      return (total_reg > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(total_reg);
   endfunction

   function automatic void mark(input int n, input logic v);
      usage_words[n / WB][n % WB] = v;
   endfunction

   // The scan stops at the first word with a clear bit, even past the limit
   function automatic logic lowest_clear(input int limit, output int n);
      int w;
      int b;
      n = 0;
      for (w = 0; w < MAP_WORDS; w++) begin
         if (usage_words[w] != '1) begin
            for (b = 0; b < WB; b++) begin
               if (!usage_words[w][b]) begin
                  n = w * WB + b;
                  return n < limit;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   // Apply one command to the mirror and return the reply it must produce
   function automatic rsp_type apply_command(input req_type r);
      rsp_type o;
      int      limit;
      int      spot;
      int      keep;
      int      i;
      limit          = usable_total();
      o.status       = ST_OK;
      o.result_block = r.block_number;
      o.bit_read     = 1'b0;
      case (r.cmd)
         CMD_ALLOC: begin
            if (free_tally != 0 && lowest_clear(limit, spot)) begin
               mark(spot, 1'b1);
               free_tally--;
               o.result_block = spot[BLOCK_W-1:0];
            end else begin
               o.status       = ST_NOSPACE;
               o.result_block = '0;
            end
         end
         CMD_FREE, CMD_READ, CMD_WRITE: begin
            if (r.block_number >= limit) begin
               o.status = ST_RANGE;
            end else if (r.cmd == CMD_FREE) begin
               // count only blocks that were actually in use, saturating
               if (usage_words[r.block_number / WB][r.block_number % WB]) begin
                  mark(r.block_number, 1'b0);
                  if (free_tally != COUNT_MAX)
                     free_tally++;
               end
            end else if (r.cmd == CMD_READ) begin
               o.bit_read = usage_words[r.block_number / WB][r.block_number % WB];
            end else begin
               mark(r.block_number, r.bit_value);
            end
         end
         CMD_INIT: begin
            keep = (reserve_reg > limit) ? limit : int'(reserve_reg);
            foreach (usage_words[k])
               usage_words[k] = '0;
            for (i = 0; i < keep; i++)
               mark(i, 1'b1);
            free_tally = REG_W'(limit - keep);
         end
         default: begin
         end
      endcase
      o.free_count_out = free_tally;
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (usage_words[k])
            usage_words[k] = '0;
         free_tally  = TOTAL_RESET;
         total_reg   = TOTAL_RESET;
         reserve_reg = RESERVE_RESET;
         due_q.delete();
      end else begin
         // track register writes
         if (csr_wr_en) begin
            if (csr_index == REG_TOTAL_BLOCKS)
               total_reg = csr_wdata;
            else
               reserve_reg = csr_wdata;
         end
         // check the reply transaction against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               flag_mismatch("reply with no request outstanding");
            end else begin
               want = due_q.pop_front();
               if (rsp_data.status != want.status)
                  flag_mismatch($sformatf("status %0d, want %0d (block %0d)",
                     rsp_data.status, want.status, want.result_block));
               if (rsp_data.result_block != want.result_block)
                  flag_mismatch($sformatf("result_block %0d, want %0d",
                     rsp_data.result_block, want.result_block));
               if (rsp_data.bit_read != want.bit_read)
                  flag_mismatch($sformatf("bit_read %0b, want %0b (block %0d)",
                     rsp_data.bit_read, want.bit_read, want.result_block));
               if (rsp_data.free_count_out != want.free_count_out)
                  flag_mismatch($sformatf("free_count_out %0d, want %0d",
                     rsp_data.free_count_out, want.free_count_out));
            end
         end
         // predict the reply of each request transaction
         if (req_valid && req_ready)
            due_q.push_back(apply_command(req_data));
      end
      replies_due <= due_q.size();
      mismatches  <= miss_tally;
   end

endmodule

// ===== dv/tb_bitmap_block_allocator.sv =====
// Testbench top for the bitmap block allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_bitmap_block_allocator;
   import bba_pkg::*;

   localparam int              LONG_HOLD       = 400;
   localparam int              QUIET_LIMIT     = 20000;
   localparam int              SETTLE_CYCLES   = 4200;
   localparam int              REG_TOP         = (1 << REG_W) - 1;
   localparam logic [2:0]      CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0]      CMD_SPARE_LAST  = 3'd7;
   localparam logic [BLOCK_W-1:0] BLOCK_LAST   = '1;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [0:0]       csr_index   = '0;
   logic [REG_W-1:0] csr_wdata   = '0;
   int               mismatches;
   int               replies_due;

   bit               gaps_on     = 1'b1;
   int               hold_orders = 0;
   int               holds_done  = 0;
   int               quiet_cycles = 0;
   int               rt;
   int               rr;
   int               p;

   bitmap_block_allocator dut (.*);

   bba_checker scoreboard (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Reply side: random stalls, plus a long hold when the stimulus asks for one
   initial begin
      @(posedge clock);
      forever begin
         if (holds_done != hold_orders) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one request transaction and hold it until accepted
   task automatic issue(input logic [2:0] code, input logic [BLOCK_W-1:0] blk,
                        input logic bv);
      int gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 7) == 0)
         gap = $urandom_range(1, 18);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{cmd: code, block_number: blk, bit_value: bv};
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait until every reply has come back
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_due != 0) @(posedge clock);
   endtask

   task automatic reprogram(input int total, input int reserved);
      wait_quiet();
      csr_wr_en <= 1'b1;
      csr_index <= REG_TOTAL_BLOCKS;
      csr_wdata <= REG_W'(total);
      @(posedge clock);
      csr_index <= REG_RESERVED_BLOCKS;
      csr_wdata <= REG_W'(reserved);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One configuration, usually opened by an init, then a random command mix
   task automatic run_phase(input int n_items, input int total, input int reserved,
                            input bit gaps, input bit hold);
      int               lim;
      int               lo;
      int               roll;
      int               i;
      logic [2:0]       code;
      logic [BLOCK_W-1:0] blk;
      reprogram(total, reserved);
      gaps_on = gaps;
      lim = (total > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : total;
      lo  = (reserved < lim) ? reserved : lim;
      if ($urandom_range(0, 4) != 0)
         issue(CMD_INIT, BLOCK_W'($urandom), 1'($urandom));
      for (i = 0; i < n_items; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 38)
            code = CMD_ALLOC;
         else if (roll < 62)
            code = CMD_FREE;
         else if (roll < 77)
            code = CMD_READ;
         else if (roll < 93)
            code = CMD_WRITE;
         else if (roll < 97)
            code = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
         else
            code = CMD_INIT;
         // aim often at the region just past the reserved blocks, where allocations land,
         // else at numbers up to just past the limit, and sometimes anywhere in the field's range
         roll = $urandom_range(0, 99);
         if (roll < 40)
            blk = BLOCK_W'($urandom_range(lo, lo + 63));
         else if (roll < 75)
            blk = BLOCK_W'($urandom_range(0, lim + 2));
         else
            blk = BLOCK_W'($urandom);
         if (hold && i == 12)
            hold_orders++;
         issue(code, blk, 1'($urandom));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Full map: first allocations, extreme block numbers, double free, spare codes
      reprogram(DEF_MAX_BLOCKS, 0);
      issue(CMD_ALLOC, '0, 1'b0);
      issue(CMD_ALLOC, BLOCK_LAST, 1'b1);
      issue(CMD_READ, '0, 1'b0);
      issue(CMD_READ, BLOCK_LAST, 1'b0);
      issue(CMD_WRITE, BLOCK_LAST, 1'b1);
      issue(CMD_READ, BLOCK_LAST, 1'b0);
      issue(CMD_FREE, BLOCK_LAST, 1'b0);
      issue(CMD_FREE, BLOCK_LAST, 1'b0);
      issue(CMD_FREE, BLOCK_W'(1), 1'b0);
      issue(CMD_SPARE_FIRST, BLOCK_LAST, 1'b1);
      issue(CMD_SPARE_LAST, '0, 1'b0);
      issue(CMD_INIT, '0, 1'b0);

      // Zero total: nothing to allocate and every number out of range
      reprogram(0, 0);
      issue(CMD_ALLOC, '0, 1'b0);
      issue(CMD_FREE, '0, 1'b0);
      issue(CMD_READ, '0, 1'b0);
      issue(CMD_WRITE, '0, 1'b1);

      // Registers at their top: total clamps to the map, reserve swallows it all
      reprogram(REG_TOP, REG_TOP);
      issue(CMD_INIT, '0, 1'b0);
      issue(CMD_ALLOC, '0, 1'b0);
      issue(CMD_FREE, BLOCK_W'(100), 1'b0);
      issue(CMD_ALLOC, '0, 1'b0);
      issue(CMD_READ, BLOCK_LAST, 1'b0);

      // Tiny map: fill it, then a nonzero count with no clear bit below the limit
      reprogram(5, 3);
      issue(CMD_INIT, '0, 1'b0);
      issue(CMD_ALLOC, '0, 1'b0);
      issue(CMD_ALLOC, '0, 1'b0);
      issue(CMD_ALLOC, '0, 1'b0);
      issue(CMD_FREE, BLOCK_W'(4), 1'b0);
      issue(CMD_WRITE, BLOCK_W'(4), 1'b1);
      issue(CMD_ALLOC, '0, 1'b0);
      issue(CMD_READ, BLOCK_W'(5), 1'b0);

      // Random phases
      run_phase(136, DEF_MAX_BLOCKS, 0, 1'b1, 1'b0);
      run_phase(60, 1, 0, 1'b1, 1'b0);
      rt = $urandom_range(2, 100);
      run_phase(136, rt, $urandom_range(0, rt + 5), 1'b1, 1'b1);
      run_phase(20, REG_TOP, DEF_MAX_BLOCKS - 1, 1'b1, 1'b0);
      run_phase(130, 40, 100, 1'b1, 1'b0);
      for (p = 0; p < 4; p++) begin
         case ($urandom_range(0, 3))
            0: rt = $urandom_range(1, 64);
            1: rt = $urandom_range(65, 2000);
            2: rt = $urandom_range(2001, DEF_MAX_BLOCKS);
            default: rt = $urandom_range(DEF_MAX_BLOCKS + 1, REG_TOP);
         endcase
         if (rt <= 2000 && $urandom_range(0, 4) == 0)
            rr = rt + $urandom_range(0, 50);
         else
            rr = $urandom_range(0, (rt < 300) ? rt : 300);
         run_phase(150, rt, rr, $urandom_range(0, 3) != 0, 1'b0);
      end
      run_phase(140, DEF_MAX_BLOCKS, $urandom_range(0, 100), 1'b0, 1'b0);

      // Drain, then give stray replies time to show up
      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/bba_pkg.sv
hw/rtl/bitmap_block_allocator.sv
dv/bba_checker.sv
dv/tb_bitmap_block_allocator.sv
